// ===== src/sorr_pkg.sv =====
// Shared types, constants and helpers for the source owner rendezvous registry
package sorr_pkg;

    localparam int NUM_SLOTS_DEF = 16;
    localparam int WORD_W        = 64;
    localparam int REQ_W         = 3;
    localparam int SLOT_W        = 4;
    localparam int STATUS_W      = 2;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_REGISTER   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_AUTHORIZE  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_UNREGISTER = 3'd2;
    localparam logic [REQ_W-1:0] REQ_PAUSE      = 3'd3;
    localparam logic [REQ_W-1:0] REQ_SELECT     = 3'd4;
    localparam logic [REQ_W-1:0] REQ_STOP       = 3'd5;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NONE    = 2'd2;

    // Mixer constants
    localparam logic [WORD_W-1:0] MIX_K1 = 64'hBF58476D1CE4E5B9;
    localparam logic [WORD_W-1:0] MIX_K2 = 64'h94D049BB133111EB;
    localparam int MIX_SH0 = 30;
    localparam int MIX_SH1 = 27;
    localparam int MIX_SH2 = 31;

    typedef struct packed {
        logic              known;
        logic              family;
        logic [WORD_W-1:0] ip_high;
        logic [WORD_W-1:0] ip_low;
    } src_key_t;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [SLOT_W-1:0] line_slot;
        logic              source_known;
        logic              source_family;
        logic [WORD_W-1:0] source_ip_high;
        logic [WORD_W-1:0] source_ip_low;
        logic              pause_value;
        logic [WORD_W-1:0] flow_hash;
    } req_payload_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [WORD_W-1:0]   generation;
        logic [WORD_W-1:0]   line_id;
        logic [SLOT_W-1:0]   slot;
        logic                close_request;
        logic                last;
    } rsp_payload_t;

    // What the request needs after the addressed slot has been read
    typedef enum logic [1:0] {
        DEC_FINAL  = 2'd0,
        DEC_EVICT  = 2'd1,
        DEC_SELECT = 2'd2
    } dec_t;

    typedef struct packed {
        logic load;
        logic rd_self;
        logic latch_self;
        logic rd_walk;
        logic walk_inc;
        logic emit_evict;
        logic mix_id;
        logic mix_flow;
        logic score;
        logic commit_final;
    } ctrl_cmd_t;

    typedef struct packed {
        dec_t dec;
        logic walk_hit;
        logic walk_last;
        logic mix_done;
        logic out_free;
    } dp_status_t;

    // Both anonymous is equal; known sources match on family and address
    function automatic logic key_equal(input src_key_t a, input src_key_t b);
        logic eq;
        eq = (a.known == b.known) &&
             (!a.known || (a.family == b.family && a.ip_high == b.ip_high &&
                           a.ip_low == b.ip_low));
        return eq;
    endfunction

    // Counter plus one, skipping zero
    function automatic logic [WORD_W-1:0] next_token(input logic [WORD_W-1:0] ctr);
        logic [WORD_W-1:0] v;
        v = ctr + 1'b1;
        if (v == '0)
        begin
            v = {{(WORD_W-1){1'b0}}, 1'b1};
        end
        return v;
    endfunction

endpackage

// ===== src/sorr_req_if.sv =====
// Request channel interface
interface sorr_req_if;
    logic                                valid;
    logic                                ready;
    logic [sorr_pkg::REQ_W-1:0]          req_type;
    logic [sorr_pkg::SLOT_W-1:0]         line_slot;
    logic                                source_known;
    logic                                source_family;
    logic [sorr_pkg::WORD_W-1:0]         source_ip_high;
    logic [sorr_pkg::WORD_W-1:0]         source_ip_low;
    logic                                pause_value;
    logic [sorr_pkg::WORD_W-1:0]         flow_hash;

    modport source (
        output valid, req_type, line_slot, source_known, source_family,
               source_ip_high, source_ip_low, pause_value, flow_hash,
        input  ready
    );
    modport sink (
        input  valid, req_type, line_slot, source_known, source_family,
               source_ip_high, source_ip_low, pause_value, flow_hash,
        output ready
    );
endinterface

// ===== src/sorr_rsp_if.sv =====
// Result channel interface
interface sorr_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [sorr_pkg::STATUS_W-1:0] status;
    logic [sorr_pkg::WORD_W-1:0]   generation;
    logic [sorr_pkg::WORD_W-1:0]   line_id;
    logic [sorr_pkg::SLOT_W-1:0]   slot;
    logic                          close_request;
    logic                          last;

    modport source (
        output valid, status, generation, line_id, slot, close_request, last,
        input  ready
    );
    modport sink (
        input  valid, status, generation, line_id, slot, close_request, last,
        output ready
    );
endinterface

// ===== src/sorr_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module sorr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ===== src/sorr_mix.sv =====
// Iterative 64-bit mixer: two constant multiplies built from 32x32 partial products
module sorr_mix (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [sorr_pkg::WORD_W-1:0] din,
    output logic                        done,
    output logic [sorr_pkg::WORD_W-1:0] dout
);
    logic [sorr_pkg::WORD_W-1:0] v_reg;
    logic [sorr_pkg::WORD_W-1:0] acc_reg;
    logic [2:0]                  step_reg;
    logic                        run_reg;
    logic                        done_reg;

    logic [31:0]                 mul_a;
    logic [31:0]                 mul_b;
    logic [sorr_pkg::WORD_W-1:0] k;
    logic [sorr_pkg::WORD_W-1:0] prod;
    logic [sorr_pkg::WORD_W-1:0] sum;
    logic [sorr_pkg::WORD_W-1:0] mixed;

    // Partial product select: lo*lo, hi*lo, lo*hi for each constant
    always_comb
    begin
        k     = (step_reg < 3'd3) ? sorr_pkg::MIX_K1 : sorr_pkg::MIX_K2;
        mul_a = (step_reg == 3'd1 || step_reg == 3'd4) ? v_reg[63:32] : v_reg[31:0];
        mul_b = (step_reg == 3'd2 || step_reg == 3'd5) ? k[63:32] : k[31:0];
        prod  = 64'(mul_a) * 64'(mul_b);
        sum   = acc_reg + {prod[31:0], 32'd0};
        mixed = (step_reg == 3'd2) ? (sum ^ (sum >> sorr_pkg::MIX_SH1))
                                   : (sum ^ (sum >> sorr_pkg::MIX_SH2));
    end

    // Step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 3'd0;
        end
        else
        begin
            done_reg <= run_reg && step_reg == 3'd5;
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= 3'd0;
            end
            else if (run_reg)
            begin
                if (step_reg == 3'd5)
                begin
                    run_reg <= 1'b0;
                end
                step_reg <= step_reg + 3'd1;
            end
        end
    end

    // Data path of the mixer
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg <= din ^ (din >> sorr_pkg::MIX_SH0);
        end
        else if (run_reg)
        begin
            case (step_reg)
                3'd0, 3'd3: acc_reg <= prod;
                3'd1, 3'd4: acc_reg <= sum;
                default:    v_reg   <= mixed;
            endcase
        end
    end

    assign done = done_reg;
    assign dout = v_reg;
endmodule

// ===== src/sorr_datapath.sv =====
// Registry state, slot store, walk counter, scoring and result register
module sorr_datapath #(
    parameter int NUM_SLOTS = sorr_pkg::NUM_SLOTS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sorr_pkg::req_payload_t req_data,
    input  sorr_pkg::ctrl_cmd_t    cmd,
    output sorr_pkg::dp_status_t   st,
    input  logic                   rsp_ready,
    output logic                   rsp_valid,
    output sorr_pkg::rsp_payload_t rsp_data
);
    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int KEY_W = $bits(sorr_pkg::src_key_t);
    localparam int ENT_W = sorr_pkg::WORD_W + KEY_W;

    typedef enum logic [2:0] {
        AC_CHECK     = 3'd0,
        AC_STOPPED   = 3'd1,
        AC_CLAIM     = 3'd2,
        AC_JOIN      = 3'd3,
        AC_TAKEOVER  = 3'd4
    } auth_cls_t;

    // Request and addressed-slot copies
    sorr_pkg::req_payload_t      req_reg;
    logic [sorr_pkg::WORD_W-1:0] self_id_reg;
    sorr_pkg::src_key_t          self_src_reg;
    logic [IDX_W-1:0]            walk_idx_reg;

    // Per-slot flags
    logic [NUM_SLOTS-1:0] inreg_reg;
    logic [NUM_SLOTS-1:0] tracked_reg;
    logic [NUM_SLOTS-1:0] actloc_reg;
    logic [NUM_SLOTS-1:0] active_reg;
    logic [NUM_SLOTS-1:0] paused_reg;
    logic [NUM_SLOTS-1:0] cur_reg;

    // Owner and counters
    logic                        owner_set_reg;
    sorr_pkg::src_key_t          owner_src_reg;
    logic [sorr_pkg::WORD_W-1:0] owner_gen_reg;
    logic [sorr_pkg::WORD_W-1:0] line_cnt_reg;
    logic [sorr_pkg::WORD_W-1:0] gen_cnt_reg;
    logic                        stopping_reg;

    // Best candidate of a select walk
    logic                        best_found_reg;
    logic [sorr_pkg::WORD_W-1:0] best_score_reg;
    logic [sorr_pkg::WORD_W-1:0] best_id_reg;
    logic [IDX_W-1:0]            best_idx_reg;

    logic                   out_valid_reg;
    sorr_pkg::rsp_payload_t out_reg;

    logic [ENT_W-1:0]            ram_rdata;
    logic [ENT_W-1:0]            ram_wdata;
    logic                        ram_we;
    logic [IDX_W-1:0]            ram_raddr;
    logic [sorr_pkg::WORD_W-1:0] rd_id;
    sorr_pkg::src_key_t          rd_src;
    sorr_pkg::src_key_t          req_src;

    logic                        mix_start;
    logic [sorr_pkg::WORD_W-1:0] mix_din;
    logic                        mix_done;
    logic [sorr_pkg::WORD_W-1:0] mix_dout;

    logic [IDX_W-1:0]            s_idx;
    logic [NUM_SLOTS-1:0]        s_mask;
    logic                        in_range;
    logic                        req_ok;
    logic                        s_inreg;
    logic                        s_tr;
    logic                        s_act;
    logic                        s_cur;
    logic                        owner_live;
    logic                        still_owns;
    logic                        any_after;
    auth_cls_t                   cls;
    logic [sorr_pkg::WORD_W-1:0] new_id;
    logic [sorr_pkg::WORD_W-1:0] new_gen;
    logic [sorr_pkg::WORD_W-1:0] auth_gen;
    sorr_pkg::rsp_payload_t      fin;
    sorr_pkg::rsp_payload_t      evict;
    logic                        w_sel;
    logic                        w_evict;
    logic                        better;

    // Slot store: line id over source key
    sorr_ram #(
        .WIDTH (ENT_W),
        .DEPTH (NUM_SLOTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s_idx),
        .wdata (ram_wdata),
        .re    (cmd.rd_self | cmd.rd_walk),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sorr_mix u_mix (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mix_start),
        .din   (mix_din),
        .done  (mix_done),
        .dout  (mix_dout)
    );

    assign rd_id     = ram_rdata[ENT_W-1 -: sorr_pkg::WORD_W];
    assign rd_src    = sorr_pkg::src_key_t'(ram_rdata[KEY_W-1:0]);
    assign ram_raddr = cmd.rd_self ? s_idx : walk_idx_reg;
    assign mix_start = cmd.mix_id | cmd.mix_flow;
    assign mix_din   = cmd.mix_id ? rd_id : (req_reg.flow_hash ^ mix_dout);

    // Addressed slot and owner checks
    always_comb
    begin
        s_idx      = IDX_W'(req_reg.line_slot);
        s_mask     = NUM_SLOTS'(1) << s_idx;
        in_range   = int'(req_reg.line_slot) < NUM_SLOTS;
        req_ok     = (req_reg.req_type > sorr_pkg::REQ_PAUSE) || in_range;
        s_inreg    = in_range && inreg_reg[s_idx];
        s_tr       = in_range && tracked_reg[s_idx];
        s_act      = in_range && active_reg[s_idx];
        s_cur      = in_range && cur_reg[s_idx];
        owner_live = owner_set_reg && owner_gen_reg != '0;
        still_owns = s_inreg && s_act && owner_live && s_cur &&
                     sorr_pkg::key_equal(self_src_reg, owner_src_reg);
        any_after  = |(inreg_reg & active_reg & cur_reg & ~s_mask);
        new_id     = sorr_pkg::next_token(line_cnt_reg);
        new_gen    = sorr_pkg::next_token(gen_cnt_reg);

        if ((in_range && actloc_reg[s_idx]) || !s_inreg || s_act)
        begin
            cls = AC_CHECK;
        end
        else if (stopping_reg)
        begin
            cls = AC_STOPPED;
        end
        else if (!owner_set_reg)
        begin
            cls = AC_CLAIM;
        end
        else if (sorr_pkg::key_equal(self_src_reg, owner_src_reg))
        begin
            cls = AC_JOIN;
        end
        else
        begin
            cls = AC_TAKEOVER;
        end

        case (cls)
            AC_CHECK:    auth_gen = still_owns ? owner_gen_reg : '0;
            AC_STOPPED:  auth_gen = '0;
            AC_JOIN:     auth_gen = owner_gen_reg;
            default:     auth_gen = new_gen;
        endcase
    end

    // Source key of a register request, cleared when anonymous
    always_comb
    begin
        req_src.known   = req_reg.source_known;
        req_src.family  = req_reg.source_known & req_reg.source_family;
        req_src.ip_high = req_reg.source_known ? req_reg.source_ip_high : '0;
        req_src.ip_low  = req_reg.source_known ? req_reg.source_ip_low : '0;
        ram_wdata       = {new_id, req_src};
        ram_we          = cmd.commit_final && in_range && !stopping_reg &&
                          req_reg.req_type == sorr_pkg::REQ_REGISTER;
    end

    // Final result of the request
    always_comb
    begin
        fin.status        = sorr_pkg::ST_REFUSED;
        fin.generation    = '0;
        fin.line_id       = '0;
        fin.slot          = '0;
        fin.close_request = 1'b0;
        fin.last          = 1'b1;
        if (req_ok)
        begin
            case (req_reg.req_type)
                sorr_pkg::REQ_REGISTER:
                begin
                    fin.slot = req_reg.line_slot;
                    if (!stopping_reg)
                    begin
                        fin.status  = sorr_pkg::ST_OK;
                        fin.line_id = new_id;
                    end
                end
                sorr_pkg::REQ_AUTHORIZE:
                begin
                    fin.slot = req_reg.line_slot;
                    if (s_tr)
                    begin
                        fin.status     = (auth_gen != '0) ? sorr_pkg::ST_OK
                                                          : sorr_pkg::ST_REFUSED;
                        fin.generation = auth_gen;
                        fin.line_id    = self_id_reg;
                    end
                end
                sorr_pkg::REQ_UNREGISTER, sorr_pkg::REQ_PAUSE:
                begin
                    fin.slot = req_reg.line_slot;
                    if (s_tr)
                    begin
                        fin.status  = sorr_pkg::ST_OK;
                        fin.line_id = self_id_reg;
                    end
                end
                sorr_pkg::REQ_SELECT:
                begin
                    if (best_found_reg)
                    begin
                        fin.status     = sorr_pkg::ST_OK;
                        fin.generation = owner_gen_reg;
                        fin.line_id    = best_id_reg;
                        fin.slot       = sorr_pkg::SLOT_W'(best_idx_reg);
                    end
                    else
                    begin
                        fin.status = sorr_pkg::ST_NONE;
                    end
                end
                sorr_pkg::REQ_STOP:
                begin
                    fin.status = sorr_pkg::ST_OK;
                end
                default:
                begin
                    fin.status = sorr_pkg::ST_REFUSED;
                end
            endcase
        end
    end

    // Eviction result and walk checks
    always_comb
    begin
        evict.status        = sorr_pkg::ST_OK;
        evict.generation    = '0;
        evict.line_id       = rd_id;
        evict.slot          = sorr_pkg::SLOT_W'(walk_idx_reg);
        evict.close_request = 1'b1;
        evict.last          = 1'b0;

        w_sel   = inreg_reg[walk_idx_reg] && active_reg[walk_idx_reg] &&
                  !paused_reg[walk_idx_reg] && cur_reg[walk_idx_reg] &&
                  sorr_pkg::key_equal(rd_src, owner_src_reg);
        w_evict = walk_idx_reg != s_idx && inreg_reg[walk_idx_reg] &&
                  !sorr_pkg::key_equal(rd_src, self_src_reg);
        better  = !best_found_reg || mix_dout > best_score_reg ||
                  (mix_dout == best_score_reg && rd_id > best_id_reg);
    end

    // Status to the controller
    always_comb
    begin
        if (req_reg.req_type == sorr_pkg::REQ_AUTHORIZE && s_tr && cls == AC_TAKEOVER)
        begin
            st.dec = sorr_pkg::DEC_EVICT;
        end
        else if (req_reg.req_type == sorr_pkg::REQ_SELECT && owner_live)
        begin
            st.dec = sorr_pkg::DEC_SELECT;
        end
        else
        begin
            st.dec = sorr_pkg::DEC_FINAL;
        end
        st.walk_hit  = (st.dec == sorr_pkg::DEC_EVICT) ? w_evict : w_sel;
        st.walk_last = walk_idx_reg == IDX_W'(NUM_SLOTS - 1);
        st.mix_done  = mix_done;
        st.out_free  = !out_valid_reg || rsp_ready;
    end

    // Registry state updates
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inreg_reg      <= '0;
            tracked_reg    <= '0;
            actloc_reg     <= '0;
            active_reg     <= '0;
            paused_reg     <= '0;
            cur_reg        <= '0;
            owner_set_reg  <= 1'b0;
            owner_src_reg  <= '0;
            owner_gen_reg  <= '0;
            line_cnt_reg   <= '0;
            gen_cnt_reg    <= '0;
            stopping_reg   <= 1'b0;
            walk_idx_reg   <= '0;
            best_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // Eviction frees the walked slot at once
            if (cmd.emit_evict)
            begin
                inreg_reg[walk_idx_reg]   <= 1'b0;
                tracked_reg[walk_idx_reg] <= 1'b0;
                actloc_reg[walk_idx_reg]  <= 1'b0;
                active_reg[walk_idx_reg]  <= 1'b0;
                paused_reg[walk_idx_reg]  <= 1'b0;
            end

            if (cmd.commit_final && req_ok)
            begin
                case (req_reg.req_type)
                    sorr_pkg::REQ_REGISTER:
                    begin
                        if (!stopping_reg)
                        begin
                            line_cnt_reg         <= new_id;
                            inreg_reg[s_idx]     <= 1'b1;
                            tracked_reg[s_idx]   <= 1'b1;
                            actloc_reg[s_idx]    <= 1'b0;
                            active_reg[s_idx]    <= 1'b0;
                            paused_reg[s_idx]    <= 1'b0;
                            cur_reg[s_idx]       <= 1'b0;
                        end
                    end
                    sorr_pkg::REQ_AUTHORIZE:
                    begin
                        if (s_tr && (cls == AC_CLAIM || cls == AC_TAKEOVER))
                        begin
                            owner_set_reg     <= 1'b1;
                            owner_src_reg     <= self_src_reg;
                            owner_gen_reg     <= new_gen;
                            gen_cnt_reg       <= new_gen;
                            cur_reg           <= s_mask;
                            active_reg[s_idx] <= 1'b1;
                            actloc_reg[s_idx] <= 1'b1;
                        end
                        else if (s_tr && cls == AC_JOIN)
                        begin
                            cur_reg[s_idx]    <= 1'b1;
                            active_reg[s_idx] <= 1'b1;
                            actloc_reg[s_idx] <= 1'b1;
                        end
                    end
                    sorr_pkg::REQ_UNREGISTER:
                    begin
                        if (s_tr)
                        begin
                            inreg_reg[s_idx]   <= 1'b0;
                            tracked_reg[s_idx] <= 1'b0;
                            actloc_reg[s_idx]  <= 1'b0;
                            active_reg[s_idx]  <= 1'b0;
                            paused_reg[s_idx]  <= 1'b0;
                            if (owner_set_reg && !any_after)
                            begin
                                owner_set_reg <= 1'b0;
                                owner_src_reg <= '0;
                                owner_gen_reg <= '0;
                            end
                        end
                    end
                    sorr_pkg::REQ_PAUSE:
                    begin
                        if (s_tr && s_inreg)
                        begin
                            paused_reg[s_idx] <= req_reg.pause_value;
                        end
                    end
                    sorr_pkg::REQ_STOP:
                    begin
                        stopping_reg <= 1'b1;
                    end
                    default:
                    begin
                        stopping_reg <= stopping_reg;
                    end
                endcase
            end

            // Walk counter
            if (cmd.load)
            begin
                walk_idx_reg <= '0;
            end
            else if (cmd.walk_inc)
            begin
                walk_idx_reg <= walk_idx_reg + 1'b1;
            end

            // Best candidate flag
            if (cmd.load)
            begin
                best_found_reg <= 1'b0;
            end
            else if (cmd.score && better)
            begin
                best_found_reg <= 1'b1;
            end

            // Result register
            if (cmd.commit_final || cmd.emit_evict)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req_data;
        end
        if (cmd.latch_self)
        begin
            self_id_reg  <= rd_id;
            self_src_reg <= rd_src;
        end
        if (cmd.score && better)
        begin
            best_score_reg <= mix_dout;
            best_id_reg    <= rd_id;
            best_idx_reg   <= walk_idx_reg;
        end
        if (cmd.commit_final)
        begin
            out_reg <= fin;
        end
        else if (cmd.emit_evict)
        begin
            out_reg <= evict;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;
endmodule

// ===== src/sorr_ctrl.sv =====
// Request sequencer: reads the addressed slot, walks slots, issues results
module sorr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output sorr_pkg::ctrl_cmd_t  cmd,
    input  sorr_pkg::dp_status_t st
);
    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_READ   = 11'b00000000010,
        S_LATCH  = 11'b00000000100,
        S_DECIDE = 11'b00000001000,
        S_WRD    = 11'b00000010000,
        S_WCHK   = 11'b00000100000,
        S_EVICT  = 11'b00001000000,
        S_H1W    = 11'b00010000000,
        S_H2W    = 11'b00100000000,
        S_WNEXT  = 11'b01000000000,
        S_FINAL  = 11'b10000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd_self = 1'b1;
                state_next  = S_LATCH;
            end
            S_LATCH:
            begin
                cmd.latch_self = 1'b1;
                state_next     = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next = (st.dec == sorr_pkg::DEC_FINAL) ? S_FINAL : S_WRD;
            end
            S_WRD:
            begin
                cmd.rd_walk = 1'b1;
                state_next  = S_WCHK;
            end
            S_WCHK:
            begin
                if (!st.walk_hit)
                begin
                    state_next = S_WNEXT;
                end
                else if (st.dec == sorr_pkg::DEC_EVICT)
                begin
                    state_next = S_EVICT;
                end
                else
                begin
                    cmd.mix_id = 1'b1;
                    state_next = S_H1W;
                end
            end
            S_EVICT:
            begin
                if (st.out_free)
                begin
                    cmd.emit_evict = 1'b1;
                    state_next     = S_WNEXT;
                end
            end
            S_H1W:
            begin
                if (st.mix_done)
                begin
                    cmd.mix_flow = 1'b1;
                    state_next   = S_H2W;
                end
            end
            S_H2W:
            begin
                if (st.mix_done)
                begin
                    cmd.score  = 1'b1;
                    state_next = S_WNEXT;
                end
            end
            S_WNEXT:
            begin
                if (st.walk_last)
                begin
                    state_next = S_FINAL;
                end
                else
                begin
                    cmd.walk_inc = 1'b1;
                    state_next   = S_WRD;
                end
            end
            S_FINAL:
            begin
                if (st.out_free)
                begin
                    cmd.commit_final = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A result beat is never loaded over one still waiting
    a_final_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit_final |-> st.out_free)
        else $error("final result issued while result register busy");

    a_evict_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_evict |-> st.out_free)
        else $error("eviction issued while result register busy");

    // Second hash starts only on the first hash's completion
    a_flow_after_id: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mix_flow |-> st.mix_done && $past(state_reg) == S_H1W)
        else $error("flow hash started without id hash");

    // A fresh request is taken only after the previous one is committed
    a_load_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == S_IDLE && !cmd.commit_final)
        else $error("request loaded mid-sequence");
endmodule

// ===== src/source_owner_rendezvous_registry_core.sv =====
// Top level of the source owner rendezvous registry
//
// Requests arrive on the req channel (valid/ready); each beat carries one
// request. Results leave on the rsp channel, one beat per result; the last
// beat of a request has last set. A takeover authorize first sends one
// close_request beat per evicted slot, in ascending slot order.
// One request is handled at a time; req.ready is high only between requests.
// Register, authorize (without takeover), unregister, pause, stop and
// rejected requests go through the read, latch, decide and final states.
// Takeover and select with a live owner walk every slot through the walk read,
// check and next states; during select each eligible slot also needs two mixes
// on the shared 32x32 multiplier of the mixer.
// The result register holds a beat while rsp.ready is low and the sequencer
// waits on it, so a stalled receiver holds the block without loss.
// Reset clears all flags, ownership and counters at once; no sweep is needed.
module source_owner_rendezvous_registry_core #(
    parameter int NUM_SLOTS = sorr_pkg::NUM_SLOTS_DEF
) (
    input logic        clk,
    input logic        rst_n,
    sorr_req_if.sink   req,
    sorr_rsp_if.source rsp
);
    sorr_pkg::ctrl_cmd_t    cmd;
    sorr_pkg::dp_status_t   st;
    sorr_pkg::req_payload_t req_data;
    sorr_pkg::rsp_payload_t rsp_data;
    logic                   in_ready;
    logic                   rsp_valid;

    // Request beat payload
    always_comb
    begin
        req_data.req_type       = req.req_type;
        req_data.line_slot      = req.line_slot;
        req_data.source_known   = req.source_known;
        req_data.source_family  = req.source_family;
        req_data.source_ip_high = req.source_ip_high;
        req_data.source_ip_low  = req.source_ip_low;
        req_data.pause_value    = req.pause_value;
        req_data.flow_hash      = req.flow_hash;
    end

    sorr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .st       (st)
    );

    sorr_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_data  (req_data),
        .cmd       (cmd),
        .st        (st),
        .rsp_ready (rsp.ready),
        .rsp_valid (rsp_valid),
        .rsp_data  (rsp_data)
    );

    assign req.ready         = in_ready;
    assign rsp.valid         = rsp_valid;
    assign rsp.status        = rsp_data.status;
    assign rsp.generation    = rsp_data.generation;
    assign rsp.line_id       = rsp_data.line_id;
    assign rsp.slot          = rsp_data.slot;
    assign rsp.close_request = rsp_data.close_request;
    assign rsp.last          = rsp_data.last;
endmodule
